FILE: rtl/core/nbbts_pkg.sv
// Package for the NAND bad-block target selector.
// Holds the field widths, the status codes, the operation codes and the shared structs.
// No dependencies.
package nbbts_pkg;

  // Field widths fixed by the interface
  localparam int unsigned BLK_W   = 11;
  localparam int unsigned MARK_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PAGE_W  = 5;
  localparam int unsigned ST_W    = 2;

  // Default geometry
  localparam int unsigned BLOCKS_DEF = 2048;

  // Block status codes
  localparam logic [ST_W-1:0] ST_UNUSED = 2'd0;
  localparam logic [ST_W-1:0] ST_ACTIVE = 2'd1;
  localparam logic [ST_W-1:0] ST_USED   = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD    = 2'd3;

  // Operation codes
  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Spare-area marker of a good block
  localparam logic [MARK_W-1:0] GOOD_MARK = 8'hFF;

  // Tracking value meaning "no used block found"
  localparam logic signed [WORD_W-1:0] ID_NONE = -32'sd1;

  typedef struct packed {
    logic                     operation;
    logic [BLK_W-1:0]         block_index;
    logic [MARK_W-1:0]        spare_marker;
    logic                     read_ok;
    logic [WORD_W-1:0]        header_magic;
    logic signed [WORD_W-1:0] header_id;
    logic signed [WORD_W-1:0] header_seq;
    logic                     scan_last;
    logic [PAGE_W-1:0]        page_index;
    logic                     write_failed;
  } item_t;

  // Candidate for the latest-used-block tracker
  typedef struct packed {
    logic                     en;
    logic [BLK_W-1:0]         blk;
    logic signed [WORD_W-1:0] id;
    logic signed [WORD_W-1:0] seq;
  } track_upd_t;

  // Current best as seen by the sequencer
  typedef struct packed {
    logic                     found;
    logic [BLK_W-1:0]         blk;
    logic signed [WORD_W-1:0] id;
  } track_best_t;

  // Sequencer status towards the top level
  typedef struct packed {
    logic busy;
    logic res_load;
    logic all_bad;
  } ctl_stat_t;

endpackage

FILE: rtl/core/nand_bad_block_target_selector.sv
// NAND bad-block target selector. Each input transaction is either a scan report
// for one block or the outcome of a write to the current target; every transaction
// returns exactly one result (target block, all-bad flag, latest set id). A final
// scan report or a failed write starts a search unless all blocks are bad; the walk
// reads the single read port of the status memory once per cycle and examines
// at most BLOCKS status entries. One transaction is in flight at a time; the next
// is accepted as soon as the previous one has moved into the output register,
// even if that result is still stalled. The status memory is not cleared: every
// block must be reported by a scan before it is read.
// Write magic_value only while no transaction is outstanding.
// Depends on nbbts_pkg and nbbts_ctrl.
module nand_bad_block_target_selector #(
  parameter int unsigned BLOCKS = nbbts_pkg::BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [nbbts_pkg::BLK_W-1:0]         in_block_index,
  input  logic [nbbts_pkg::MARK_W-1:0]        in_spare_marker,
  input  logic                                in_read_ok,
  input  logic [nbbts_pkg::WORD_W-1:0]        in_header_magic,
  input  logic signed [nbbts_pkg::WORD_W-1:0] in_header_id,
  input  logic signed [nbbts_pkg::WORD_W-1:0] in_header_seq,
  input  logic                                in_scan_last,
  input  logic [nbbts_pkg::PAGE_W-1:0]        in_page_index,
  input  logic                                in_write_failed,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nbbts_pkg::BLK_W-1:0]         out_target_block,
  output logic                                out_all_bad,
  output logic signed [nbbts_pkg::WORD_W-1:0] out_latest_id,
  // configuration: magic_value
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nbbts_pkg::WORD_W-1:0]        cfg_data
);
  import nbbts_pkg::*;

  item_t                    item_r;
  logic [WORD_W-1:0]        magic_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]         out_target_r;
  logic                     out_all_bad_r;
  logic signed [WORD_W-1:0] out_latest_r;
  logic                     in_take;
  logic                     res_ready;
  ctl_stat_t                stat;
  logic [BLK_W-1:0]         target;
  logic signed [WORD_W-1:0] latest_id;

  // Accept only while the sequencer is idle
  assign in_stall  = stat.busy;
  assign in_take   = in_valid && !in_stall;
  // The output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Hold the accepted transaction for the whole of its processing
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.operation    <= in_operation;
      item_r.block_index  <= in_block_index;
      item_r.spare_marker <= in_spare_marker;
      item_r.read_ok      <= in_read_ok;
      item_r.header_magic <= in_header_magic;
      item_r.header_id    <= in_header_id;
      item_r.header_seq   <= in_header_seq;
      item_r.scan_last    <= in_scan_last;
      item_r.page_index   <= in_page_index;
      item_r.write_failed <= in_write_failed;
    end
  end

  // Magic register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      magic_r <= cfg_data;
    end
  end

  nbbts_ctrl #(
    .BLOCKS (BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_take),
    .item      (item_r),
    .magic     (magic_r),
    .res_ready (res_ready),
    .stat      (stat),
    .target    (target),
    .latest_id (latest_id)
  );

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_load) begin
      out_target_r  <= target;
      out_all_bad_r <= stat.all_bad;
      out_latest_r  <= latest_id;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_block = out_target_r;
  assign out_all_bad      = out_all_bad_r;
  assign out_latest_id    = out_latest_r;

endmodule

FILE: rtl/core/nbbts_status_ram.sv
// Block status memory: one 2-bit entry per flash block.
// Synchronous write and registered read.
// Depends on nbbts_pkg.
module nbbts_status_ram #(
  parameter int unsigned DEPTH = nbbts_pkg::BLOCKS_DEF,
  parameter int unsigned AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [nbbts_pkg::ST_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [nbbts_pkg::ST_W-1:0] rdata
);
  import nbbts_pkg::*;

  logic [ST_W-1:0] mem [DEPTH];
  logic [ST_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/nbbts_tracker.sv
// Latest-used-block tracker: highest set id, then highest sequence number.
// Cleared only by reset, so later scans continue from the earlier best.
// Depends on nbbts_pkg.
module nbbts_tracker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nbbts_pkg::track_upd_t  upd,
  output nbbts_pkg::track_best_t best
);
  import nbbts_pkg::*;

  logic                     found_r, found_nxt;
  logic [BLK_W-1:0]         blk_r, blk_nxt;
  logic signed [WORD_W-1:0] id_r, id_nxt;
  logic signed [WORD_W-1:0] seq_r, seq_nxt;
  logic                     better;

  always_comb begin
    better    = !found_r || (upd.id > id_r) || ((upd.id == id_r) && (upd.seq > seq_r));
    found_nxt = found_r;
    blk_nxt   = blk_r;
    id_nxt    = id_r;
    seq_nxt   = seq_r;
    if (upd.en && better) begin
      found_nxt = 1'b1;
      blk_nxt   = upd.blk;
      id_nxt    = upd.id;
      seq_nxt   = upd.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      blk_r   <= '0;
      id_r    <= ID_NONE;
      seq_r   <= ID_NONE;
    end else begin
      found_r <= found_nxt;
      blk_r   <= blk_nxt;
      id_r    <= id_nxt;
      seq_r   <= seq_nxt;
    end
  end

  assign best.found = found_r;
  assign best.blk   = blk_r;
  assign best.id    = id_r;

endmodule

FILE: rtl/core/nbbts_ctrl.sv
// Sequencer: classifies each transaction, writes the status memory and walks it
// one entry per cycle to find the next non-bad block. Depends on nbbts_pkg,
// nbbts_status_ram and nbbts_tracker.
module nbbts_ctrl #(
  parameter int unsigned BLOCKS = nbbts_pkg::BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  nbbts_pkg::item_t            item,
  input  logic [nbbts_pkg::WORD_W-1:0] magic,
  input  logic                        res_ready,
  output nbbts_pkg::ctl_stat_t        stat,
  output logic [nbbts_pkg::BLK_W-1:0] target,
  output logic signed [nbbts_pkg::WORD_W-1:0] latest_id
);
  import nbbts_pkg::*;

  localparam int unsigned BIDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned WIDE_W = (BIDX_W > BLK_W) ? BIDX_W : BLK_W;
  localparam int unsigned CMP_W  = WIDE_W + 1;
  localparam int unsigned CNT_W  = $clog2(BLOCKS + 1);
  localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(BLOCKS - 1);
  localparam logic [CNT_W-1:0]  CNT_ALL  = CNT_W'(BLOCKS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_ARM  = 5'b00100,
    S_SEEK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [BIDX_W-1:0] cur_r, cur_nxt;
  logic              none_good_r, none_good_nxt;
  logic [BIDX_W-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0]  issued_r, issued_nxt;
  logic              pend_r, pend_nxt;
  logic [BIDX_W-1:0] pend_addr_r, pend_addr_nxt;

  logic              mem_we;
  logic [BIDX_W-1:0] mem_waddr;
  logic [ST_W-1:0]   mem_wdata;
  logic              mem_re;
  logic [ST_W-1:0]   mem_rdata;

  logic [WIDE_W-1:0] blk_wide, best_wide, cur_wide;
  logic              blk_in;
  logic              is_used;
  logic [BIDX_W-1:0] seek_start;
  logic              res_load;
  track_upd_t        upd;
  track_best_t       best;

  function automatic logic [BIDX_W-1:0] next_idx(input logic [BIDX_W-1:0] x);
    next_idx = (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  nbbts_status_ram #(
    .DEPTH (BLOCKS),
    .AW    (BIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cand_r),
    .rdata (mem_rdata)
  );

  nbbts_tracker u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .best  (best)
  );

  assign blk_wide   = WIDE_W'(item.block_index);
  assign best_wide  = WIDE_W'(best.blk);
  assign cur_wide   = WIDE_W'(cur_r);
  assign blk_in     = CMP_W'(blk_wide) < CMP_W'(BLOCKS);
  assign is_used    = (item.spare_marker == GOOD_MARK) && item.read_ok &&
                      (item.header_magic == magic);
  assign seek_start = (item.operation == OP_SCAN) ?
                      (best.found ? best_wide[BIDX_W-1:0] : LAST_IDX) : cur_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    none_good_nxt = none_good_r;
    cand_nxt      = cand_r;
    issued_nxt    = issued_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    mem_we        = 1'b0;
    mem_waddr     = blk_wide[BIDX_W-1:0];
    mem_wdata     = ST_UNUSED;
    mem_re        = 1'b0;
    upd.en        = 1'b0;
    upd.blk       = item.block_index;
    upd.id        = item.header_id;
    upd.seq       = item.header_seq;
    res_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item.operation == OP_SCAN) begin
          mem_we = blk_in;
          if (item.spare_marker != GOOD_MARK) begin
            mem_wdata = ST_BAD;
          end else if (is_used) begin
            mem_wdata = ST_USED;
          end else begin
            mem_wdata = ST_UNUSED;
          end
          upd.en    = blk_in && is_used;
          state_nxt = (item.scan_last && !none_good_r) ? S_ARM : S_DONE;
        end else if (!none_good_r) begin
          mem_we    = 1'b1;
          mem_waddr = cur_r;
          if (item.write_failed) begin
            mem_wdata = ST_BAD;
          end else if (item.page_index == '0) begin
            mem_wdata = ST_USED;
          end else begin
            mem_wdata = ST_ACTIVE;
          end
          state_nxt = item.write_failed ? S_ARM : S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ARM: begin
        // tracker is settled now; seed the walk one past the start block
        cand_nxt   = next_idx(seek_start);
        issued_nxt = '0;
        pend_nxt   = 1'b0;
        state_nxt  = S_SEEK;
      end
      S_SEEK: begin
        if (pend_r && (mem_rdata != ST_BAD)) begin
          cur_nxt   = pend_addr_r;
          state_nxt = S_DONE;
        end else if (pend_r && (issued_r == CNT_ALL)) begin
          // every block has been looked at and all are bad
          none_good_nxt = 1'b1;
          cur_nxt       = '0;
          state_nxt     = S_DONE;
        end else begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = cand_r;
          cand_nxt      = next_idx(cand_r);
          issued_nxt    = issued_r + 1'b1;
        end
      end
      S_DONE: begin
        res_load = res_ready;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      none_good_r <= 1'b0;
      pend_r      <= 1'b0;
      issued_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      none_good_r <= none_good_nxt;
      pend_r      <= pend_nxt;
      issued_r    <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  assign stat.busy     = (state_r != S_IDLE);
  assign stat.res_load = res_load;
  assign stat.all_bad  = none_good_r;
  assign target        = none_good_r ? '0 : cur_wide[BLK_W-1:0];
  assign latest_id     = best.id;

endmodule

FILE: rtl/core/nbbts_checker.sv
// Port-level checker for the NAND bad-block target selector, bound to the top level.
// Depends on nbbts_pkg.
module nbbts_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [nbbts_pkg::BLK_W-1:0]  out_target_block,
  input logic                         out_all_bad
);
  import nbbts_pkg::*;

  logic bad_seen_r;

  // Remember that an all-bad result has been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_all_bad) begin
      bad_seen_r <= 1'b1;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_target_block) && $stable(out_all_bad))
    else $error("stalled result changed or vanished");

  a_bad_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_all_bad |-> out_target_block == '0)
    else $error("all-bad result carries a nonzero target");

  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_seen_r |-> out_all_bad)
    else $error("all-bad state cleared without reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while one is in progress");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind nand_bad_block_target_selector nbbts_checker u_nbbts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_target_block (out_target_block),
  .out_all_bad      (out_all_bad)
);

FILE: dv/tb_nand_bad_block_target_selector.sv
// Self-checking bench for nand_bad_block_target_selector: a directed table, a scan of a
// low window and random scan/write traffic, checked against a predictor or typed rows.
// Depends on nbbts_pkg and the selector RTL.
module tb_nand_bad_block_target_selector;
  import nbbts_pkg::*;

  localparam logic signed [WORD_W-1:0] ID_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] ID_MIN = 32'sh8000_0000;
  // Blocks 0 .. WIN-1 are scanned in full and carry the random traffic
  localparam int WIN = 160;

  // One result transaction: what the selector reports after each input transaction
  typedef struct packed {
    logic [BLK_W-1:0]         target;
    logic                     all_bad;
    logic signed [WORD_W-1:0] latest;
  } sel_res_t;

  // Directed stimulus row; typed rows carry a hand-written result
  typedef struct {
    item_t    it;
    bit       typed;
    sel_res_t res;
  } step_row_t;

  logic                      clk;
  logic                      rst_n           = 1'b0;
  logic                      in_valid        = 1'b0;
  logic                      in_stall;
  logic                      in_operation    = OP_SCAN;
  logic [BLK_W-1:0]          in_block_index  = '0;
  logic [MARK_W-1:0]         in_spare_marker = GOOD_MARK;
  logic                      in_read_ok      = 1'b0;
  logic [WORD_W-1:0]         in_header_magic = '0;
  logic signed [WORD_W-1:0]  in_header_id    = '0;
  logic signed [WORD_W-1:0]  in_header_seq   = '0;
  logic                      in_scan_last    = 1'b0;
  logic [PAGE_W-1:0]         in_page_index   = '0;
  logic                      in_write_failed = 1'b0;
  logic                      out_valid;
  logic                      out_stall       = 1'b0;
  logic [BLK_W-1:0]          out_target_block;
  logic                      out_all_bad;
  logic signed [WORD_W-1:0]  out_latest_id;
  logic                      cfg_valid       = 1'b0;
  logic                      cfg_ready;
  logic [WORD_W-1:0]         cfg_data        = '0;

  // Predictor state: status table, target and latest-block tracking
  logic [ST_W-1:0]           blk_state [BLOCKS_DEF];
  bit                        seen      [BLOCKS_DEF];
  logic [BLK_W-1:0]          tgt_blk   = '0;
  bit                        exhausted = 1'b0;
  bit                        have_best = 1'b0;
  logic [BLK_W-1:0]          best_blk  = '0;
  logic signed [WORD_W-1:0]  best_id   = ID_NONE;
  logic signed [WORD_W-1:0]  best_seq  = ID_NONE;
  logic [WORD_W-1:0]         magic_reg = '0;

  // Results still owed by the selector, oldest first
  sel_res_t                  pending[$];
  int                        errs = 0;
  // Suppress random idling on both sides while set
  bit                        calm = 1'b0;

  nand_bad_block_target_selector u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_block_index   (in_block_index),
    .in_spare_marker  (in_spare_marker),
    .in_read_ok       (in_read_ok),
    .in_header_magic  (in_header_magic),
    .in_header_id     (in_header_id),
    .in_header_seq    (in_header_seq),
    .in_scan_last     (in_scan_last),
    .in_page_index    (in_page_index),
    .in_write_failed  (in_write_failed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_target_block (out_target_block),
    .out_all_bad      (out_all_bad),
    .out_latest_id    (out_latest_id),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the selector hangs
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Move the target to the next block after start that is not bad, with wrap;
  // give up for good when the whole table is bad.
  function automatic void seek_from(input int start);
    int cand;
    int k;
    if (exhausted) return;
    cand = start;
    for (k = 0; k < BLOCKS_DEF; k++) begin
      cand = (cand + 1) % BLOCKS_DEF;
      if (blk_state[cand] != ST_BAD) begin
        tgt_blk = BLK_W'(cand);
        return;
      end
    end
    exhausted = 1'b1;
    tgt_blk   = '0;
  endfunction

  // True when a walk after start ends on a reported block; entry ovr_blk is taken
  // to hold ovr_st, as it will once the transaction has been applied
  function automatic bit walk_ok(input int start, input int ovr_blk,
                                 input logic [ST_W-1:0] ovr_st);
    int              cand;
    int              k;
    logic [ST_W-1:0] st;
    if (exhausted) return 1'b1;
    cand = start;
    for (k = 0; k < BLOCKS_DEF; k++) begin
      cand = (cand + 1) % BLOCKS_DEF;
      if (cand == ovr_blk) st = ovr_st;
      else if (!seen[cand]) return 1'b0;
      else st = blk_state[cand];
      if (st != ST_BAD) return 1'b1;
    end
    return 1'b1;
  endfunction

  // Drop the search trigger of a transaction whose walk would reach a block
  // that no scan has described yet
  function automatic item_t make_safe(input item_t it);
    logic [ST_W-1:0] st;
    bit              used;
    bit              wins;
    int              start;
    if (exhausted) return it;
    if (it.operation == OP_WRITE) begin
      if (it.write_failed && !walk_ok(int'(tgt_blk), int'(tgt_blk), ST_BAD))
        it.write_failed = 1'b0;
    end else if (it.scan_last) begin
      used = (it.spare_marker == GOOD_MARK) && it.read_ok && (it.header_magic == magic_reg);
      if (it.spare_marker != GOOD_MARK) st = ST_BAD;
      else if (used) st = ST_USED;
      else st = ST_UNUSED;
      wins = used && (!have_best || it.header_id > best_id ||
                      (it.header_id == best_id && it.header_seq > best_seq));
      if (wins) start = int'(it.block_index);
      else if (have_best) start = int'(best_blk);
      else start = BLOCKS_DEF - 1;
      if (!walk_ok(start, int'(it.block_index), st)) it.scan_last = 1'b0;
    end
    return it;
  endfunction

  // Apply one accepted transaction to the predictor and return the result it owes
  function automatic sel_res_t step_selector(input item_t it);
    sel_res_t r;
    if (it.operation == OP_SCAN) begin
      seen[it.block_index] = 1'b1;
      if (it.spare_marker != GOOD_MARK) begin
        blk_state[it.block_index] = ST_BAD;
      end else if (!it.read_ok || it.header_magic != magic_reg) begin
        blk_state[it.block_index] = ST_UNUSED;
      end else begin
        blk_state[it.block_index] = ST_USED;
        // Highest id wins, ties go to the higher sequence number
        if (!have_best || it.header_id > best_id ||
            (it.header_id == best_id && it.header_seq > best_seq)) begin
          have_best = 1'b1;
          best_id   = it.header_id;
          best_seq  = it.header_seq;
          best_blk  = it.block_index;
        end
      end
      if (it.scan_last && !exhausted)
        seek_from(have_best ? int'(best_blk) : BLOCKS_DEF - 1);
    end else if (!exhausted) begin
      seen[tgt_blk] = 1'b1;
      if (it.write_failed) begin
        blk_state[tgt_blk] = ST_BAD;
        seek_from(int'(tgt_blk));
      end else begin
        blk_state[tgt_blk] = (it.page_index == '0) ? ST_USED : ST_ACTIVE;
      end
    end
    r.target  = exhausted ? '0 : tgt_blk;
    r.all_bad = exhausted;
    r.latest  = best_id;
    return r;
  endfunction

  // Scan report; the write-only fields carry junk, which the selector must ignore
  function automatic item_t mk_scan(input logic [BLK_W-1:0] blk, input logic [MARK_W-1:0] sp,
                                    input logic rok, input logic [WORD_W-1:0] mg,
                                    input logic signed [WORD_W-1:0] id,
                                    input logic signed [WORD_W-1:0] seq, input logic fin);
    item_t it;
    it.operation    = OP_SCAN;
    it.block_index  = blk;
    it.spare_marker = sp;
    it.read_ok      = rok;
    it.header_magic = mg;
    it.header_id    = id;
    it.header_seq   = seq;
    it.scan_last    = fin;
    it.page_index   = PAGE_W'($urandom_range(31));
    it.write_failed = 1'($urandom_range(1));
    return it;
  endfunction

  // Write outcome; the scan fields carry junk
  function automatic item_t mk_write(input logic [PAGE_W-1:0] pg, input logic failed);
    item_t it;
    it.operation    = OP_WRITE;
    it.block_index  = BLK_W'($urandom_range(BLOCKS_DEF - 1));
    it.spare_marker = MARK_W'($urandom_range(255));
    it.read_ok      = 1'($urandom_range(1));
    it.header_magic = $urandom;
    it.header_id    = $urandom;
    it.header_seq   = $urandom;
    it.scan_last    = 1'($urandom_range(1));
    it.page_index   = pg;
    it.write_failed = failed;
    return it;
  endfunction

  // Value close to base, saturated, so that ties and near misses are common
  function automatic logic signed [WORD_W-1:0] nudge(input logic signed [WORD_W-1:0] base);
    longint v;
    v = longint'(base) + longint'($urandom_range(5)) - 64'sd2;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[WORD_W-1:0];
  endfunction

  // Mostly well-formed reports around the current best; some bad, unread or foreign
  function automatic item_t gen_report(input int blk, input bit fin);
    int                       r;
    logic [MARK_W-1:0]        sp;
    logic                     rok;
    logic [WORD_W-1:0]        mg;
    logic signed [WORD_W-1:0] id;
    logic signed [WORD_W-1:0] seq;
    r   = $urandom_range(99);
    sp  = GOOD_MARK;
    rok = 1'b1;
    mg  = magic_reg;
    if (r < 12) sp = MARK_W'($urandom_range(254));
    else if (r < 20) rok = 1'b0;
    else if (r < 28) mg = magic_reg ^ (32'h1 << $urandom_range(31));
    if ($urandom_range(99) < 6) begin
      id  = $urandom;
      seq = $urandom;
    end else begin
      id  = nudge(best_id);
      seq = nudge(best_seq);
    end
    return mk_scan(BLK_W'(blk), sp, rok, mg, id, seq, fin);
  endfunction

  function automatic item_t gen_mixed();
    logic [PAGE_W-1:0] pg;
    pg = ($urandom_range(99) < 30) ? '0 : PAGE_W'($urandom_range(31, 1));
    if ($urandom_range(99) < 45) return mk_write(pg, $urandom_range(99) < 25);
    return gen_report($urandom_range(WIN - 1), $urandom_range(99) < 10);
  endfunction

  function automatic void shuffle_blocks(output int ord [WIN]);
    int j;
    int tmp;
    for (int i = 0; i < WIN; i++) ord[i] = i;
    for (int i = WIN - 1; i > 0; i--) begin
      j      = $urandom_range(i);
      tmp    = ord[i];
      ord[i] = ord[j];
      ord[j] = tmp;
    end
  endfunction

  // Present one input transaction, idling at random first; hold it until accepted,
  // then record what the selector owes for it.
  task automatic push_txn(input item_t it, input bit typed, input sel_res_t res);
    sel_res_t pred;
    item_t    drv;
    drv = make_safe(it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= drv.operation;
    in_block_index  <= drv.block_index;
    in_spare_marker <= drv.spare_marker;
    in_read_ok      <= drv.read_ok;
    in_header_magic <= drv.header_magic;
    in_header_id    <= drv.header_id;
    in_header_seq   <= drv.header_seq;
    in_scan_last    <= drv.scan_last;
    in_page_index   <= drv.page_index;
    in_write_failed <= drv.write_failed;
    do @(posedge clk); while (in_stall);
    pred = step_selector(drv);
    pending.push_back(typed ? res : pred);
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Change magic_value only once every owed result has come back
  task automatic write_magic(input logic [WORD_W-1:0] val);
    park_input();
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    magic_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall at random, drop idling while calm
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 23);
  end

  // Compare every accepted result transaction with the oldest owed one
  always @(posedge clk) begin
    sel_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected result: target_block %0d, all_bad %0d, latest_id %0d",
               out_target_block, out_all_bad, out_latest_id);
        errs++;
      end else begin
        w = pending.pop_front();
        if (out_target_block !== w.target) begin
          $error("target_block: expected %0d, actual %0d", w.target, out_target_block);
          errs++;
        end
        if (out_all_bad !== w.all_bad) begin
          $error("all_bad: expected %0d, actual %0d", w.all_bad, out_all_bad);
          errs++;
        end
        if (out_latest_id !== w.latest) begin
          $error("latest_id: expected %0d, actual %0d", w.latest, out_latest_id);
          errs++;
        end
      end
    end
  end

  initial begin : stim
    step_row_t dir_rows[$];
    int        order [WIN];

    // Directed table, run with magic_value 0. Only blocks already reported are ever
    // walked by a search, so no unwritten status entry is read.
    // Write outcome straight after reset: header page of block 0
    dir_rows.push_back('{mk_write(5'd0, 1'b0), 1'b1, {11'd0, 1'b0, ID_NONE}});
    // Lowest id becomes the first best
    dir_rows.push_back('{mk_scan(11'd0, GOOD_MARK, 1'b1, 32'h0, ID_MIN, 32'sd0, 1'b0),
                         1'b1, {11'd0, 1'b0, ID_MIN}});
    // Top block overtakes it
    dir_rows.push_back('{mk_scan(11'd2047, GOOD_MARK, 1'b1, 32'h0, 32'sd10, ID_MIN, 1'b0),
                         1'b1, {11'd0, 1'b0, 32'sd10}});
    // Bad marker wins over a perfect header carrying extreme id and sequence
    dir_rows.push_back('{mk_scan(11'd1, 8'h00, 1'b1, 32'h0, ID_MAX, ID_MAX, 1'b0),
                         1'b1, {11'd0, 1'b0, 32'sd10}});
    // Failed header read
    dir_rows.push_back('{mk_scan(11'd2, GOOD_MARK, 1'b0, 32'h0, 32'sd11, 32'sd0, 1'b0),
                         1'b1, {11'd0, 1'b0, 32'sd10}});
    // Foreign magic
    dir_rows.push_back('{mk_scan(11'd3, GOOD_MARK, 1'b1, 32'hFFFF_FFFF, 32'sd12, 32'sd0, 1'b0),
                         1'b1, {11'd0, 1'b0, 32'sd10}});
    // Final report: search starts after block 2047 and wraps to block 0
    dir_rows.push_back('{mk_scan(11'd4, 8'hFE, 1'b1, 32'h0, 32'sd0, 32'sd0, 1'b1), 1'b0, '0});
    // Failed write: skip bad block 1, land on 2
    dir_rows.push_back('{mk_write(5'd0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_write(5'd31, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_write(5'd17, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_write(5'd5, 1'b1), 1'b0, '0});
    // Second scan continues from the earlier best: equal ids settled by sequence
    dir_rows.push_back('{mk_scan(11'd1024, GOOD_MARK, 1'b1, 32'h0, 32'sd20, 32'sd5, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_scan(11'd1025, GOOD_MARK, 1'b1, 32'h0, 32'sd20, ID_MAX, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_scan(11'd1026, 8'h7F, 1'b1, 32'h0, 32'sd0, 32'sd0, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_scan(11'd1027, 8'h01, 1'b1, 32'h0, 32'sd0, 32'sd0, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_scan(11'd1029, 8'hFF, 1'b0, 32'h0, 32'sd0, 32'sd0, 1'b0),
                         1'b0, '0});
    // Exact tie does not move the best; search skips two bad blocks to 1028
    dir_rows.push_back('{mk_scan(11'd1028, GOOD_MARK, 1'b1, 32'h0, 32'sd20, ID_MAX, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{mk_write(5'd0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_write(5'd0, 1'b0), 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_magic(32'h0);
    foreach (dir_rows[i]) push_txn(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    // Scan the whole low window in random order before the random traffic
    write_magic($urandom);
    shuffle_blocks(order);
    for (int i = 0; i < WIN; i++)
      push_txn(gen_report(order[i], i == WIN - 1), 1'b0, '0);

    // Random traffic; hold both sides busy for the first stretch
    calm = 1'b1;
    for (int i = 0; i < 120; i++) begin
      if (i == 70) calm = 1'b0;
      push_txn(gen_mixed(), 1'b0, '0);
    end

    write_magic(32'hFFFF_FFFF);
    repeat (100) push_txn(gen_mixed(), 1'b0, '0);

    // Drain, then allow one worst-case search for any stray result
    park_input();
    while (pending.size() != 0) @(posedge clk);
    repeat (BLOCKS_DEF + 16) @(posedge clk);
    if (errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/nbbts_pkg.sv
rtl/core/nbbts_status_ram.sv
rtl/core/nbbts_tracker.sv
rtl/core/nbbts_ctrl.sv
rtl/core/nand_bad_block_target_selector.sv
rtl/core/nbbts_checker.sv
dv/tb_nand_bad_block_target_selector.sv
